@@ rtl/vshs_pkg.sv @@
package vshs_pkg;

  localparam int BUCKETS     = 4096;
  localparam int CAPACITY    = 8192;
  localparam int MAP_SIZE    = 256;
  localparam int MAP_OFFSET  = 128;
  localparam int SCAN_LEVELS = 15;

  localparam int BW        = $clog2(BUCKETS);
  localparam int CW        = $clog2(CAPACITY);
  localparam int LW        = CW + 1;
  localparam int MW        = $clog2(MAP_SIZE);
  localparam int MAP_CELLS = MAP_SIZE * MAP_SIZE;
  localparam int MCW       = 2 * MW;
  localparam int LVW       = $clog2(SCAN_LEVELS + 1);
  localparam int CLR_N     = (MAP_CELLS > BUCKETS) ? MAP_CELLS : BUCKETS;
  localparam int CNW       = $clog2(CLR_N) + 1;

  localparam logic [31:0] HASH_KX = 32'd73856093;
  localparam logic [31:0] HASH_KY = 32'd19349663;
  localparam logic [31:0] HASH_KZ = 32'd83492791;

  localparam logic [LW-1:0] NO_ENTRY = LW'(CAPACITY);

  localparam logic [1:0] ACT_GET    = 2'd0;
  localparam logic [1:0] ACT_SET    = 2'd1;
  localparam logic [1:0] ACT_HEIGHT = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
    logic [3:0]         block_kind;
  } req_t;

  typedef struct packed {
    logic [3:0]         found_kind;
    logic               ok;
    logic signed [15:0] column_top;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_HASH, ST_HEAD_RD, ST_HEAD_WT, ST_CHK, ST_ENT_WT,
    ST_FOUND, ST_MISS, ST_UNLINK, ST_SCAN_NEXT, ST_POOL_RD, ST_POOL_WT,
    ST_COL_RD, ST_COL_WT
  } state_e;

endpackage

@@ rtl/voxel_spatial_hash_store.sv @@
// voxel store: a 4-bit block kind per signed 3-d coordinate, chained hash
// table over a fixed entry pool, plus a column-height map
//
// request channel: req_i is taken at a clock edge with start high and busy
// low. busy stays high while the request is worked on.
// result channel: done_o is high for exactly one cycle with rsp_o; the
// receiver cannot stall, so the result must be taken in that cycle.
//
// sequencing: the bucket hash runs on one shared multiplier, x, y then z.
// a lookup then reads the bucket head and walks the chain (head read, entry
// read/compare per entry). a removal inside the map adds one lookup per
// scanned level (15 levels) to rebuild the column height. a height query
// reads the column map only. the chain walk through the entry memories sets
// the lookup time; one request is in flight at a time.
//
// reset: a clearing pass writes every column-height cell to -1 and every
// bucket head to empty, one cell per cycle, with busy high. the free list
// needs no pass: a high-water mark makes slots never handed out read as
// their own index.
module voxel_spatial_hash_store
  import vshs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  state_e state_q, state_d;

  // request registers
  logic [1:0]  act_q, act_d;
  logic [15:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic [3:0]  kind_q, kind_d;

  // walk and bookkeeping registers
  logic [CNW-1:0]  clr_q, clr_d;
  logic [1:0]      step_q, step_d;
  logic [BW-1:0]   hash_q, hash_d;
  logic [LW-1:0]   cur_q, cur_d, prev_q, prev_d, head_q, head_d, link_q, link_d;
  logic [3:0]      fkind_q, fkind_d;
  logic [LW-1:0]   vc_q, vc_d, hw_q, hw_d;
  logic            scan_q, scan_d;
  logic [LVW-1:0]  level_q, level_d;
  logic [15:0]     top_q, top_d;
  logic            done_q, done_d;
  rsp_t            rsp_q, rsp_d;

  // memories
  logic [LW-1:0] bh_mem [BUCKETS];
  logic [47:0]   key_mem [CAPACITY];
  logic [3:0]    kind_mem [CAPACITY];
  logic [LW-1:0] link_mem [CAPACITY];
  logic [CW-1:0] pool_mem [CAPACITY];
  logic [15:0]   col_mem [MAP_CELLS];

  logic          bh_we;
  logic [BW-1:0] bh_addr;
  logic [LW-1:0] bh_wd, bh_rd_q;

  logic          key_we, kind_we, link_we;
  logic [CW-1:0] ent_addr;
  logic [47:0]   key_wd, key_rd_q;
  logic [3:0]    kind_wd, kind_rd_q;
  logic [LW-1:0] link_wd, link_rd_q;

  logic          pool_we;
  logic [CW-1:0] pool_addr, pool_wd, pool_rd_q;

  logic           col_we;
  logic [MCW-1:0] col_addr;
  logic [15:0]    col_wd, col_rd_q;

  always_ff @(posedge clk_i) begin
    if (bh_we) bh_mem[bh_addr] <= bh_wd;
    bh_rd_q <= bh_mem[bh_addr];
  end

  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[ent_addr] <= key_wd;
    if (kind_we) kind_mem[ent_addr] <= kind_wd;
    if (link_we) link_mem[ent_addr] <= link_wd;
    key_rd_q  <= key_mem[ent_addr];
    kind_rd_q <= kind_mem[ent_addr];
    link_rd_q <= link_mem[ent_addr];
  end

  always_ff @(posedge clk_i) begin
    if (pool_we) pool_mem[pool_addr] <= pool_wd;
    pool_rd_q <= pool_mem[pool_addr];
  end

  always_ff @(posedge clk_i) begin
    if (col_we) col_mem[col_addr] <= col_wd;
    col_rd_q <= col_mem[col_addr];
  end

  // lookup key: y comes from the scan level during a rescan
  logic [15:0] y_l;
  logic [47:0] key_l;
  assign y_l   = scan_q ? 16'(level_q) : y_q;
  assign key_l = {x_q, y_l, z_q};

  // shared hash multiplier, one coordinate per cycle, only low bucket bits matter
  logic [15:0]     mul_c;
  logic [31:0]     mul_k, mul_c32;
  logic [2*BW-1:0] mul_p;
  always_comb begin
    case (step_q)
      2'd0:    begin mul_c = x_q; mul_k = HASH_KX; end
      2'd1:    begin mul_c = y_l; mul_k = HASH_KY; end
      default: begin mul_c = z_q; mul_k = HASH_KZ; end
    endcase
  end
  assign mul_c32 = {{16{mul_c[15]}}, mul_c};
  assign mul_p   = mul_c32[BW-1:0] * mul_k[BW-1:0];

  // column index and map bounds
  localparam logic [17:0] OFS = 18'(MAP_OFFSET);
  localparam logic [17:0] MSZ = 18'(MAP_SIZE);
  logic [17:0]    cx, cz;
  logic           in_map;
  logic [MCW-1:0] col_idx;
  assign cx      = {{2{x_q[15]}}, x_q} + OFS;
  assign cz      = {{2{z_q[15]}}, z_q} + OFS;
  assign in_map  = !cx[17] && !cz[17] && (cx < MSZ) && (cz < MSZ);
  assign col_idx = {cz[MW-1:0], cx[MW-1:0]};

  logic          pool_fresh;
  logic [CW-1:0] slot;
  assign pool_fresh = (vc_q >= hw_q);
  assign slot       = pool_fresh ? vc_q[CW-1:0] : pool_rd_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == CNW'(CLR_N - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          case (req_i.action)
            ACT_GET, ACT_SET: state_d = ST_HASH;
            ACT_HEIGHT:       state_d = ST_COL_RD;
            default:          state_d = ST_IDLE;
          endcase
        end
      end
      ST_HASH:    if (step_q == 2'd2) state_d = ST_HEAD_RD;
      ST_HEAD_RD: state_d = ST_HEAD_WT;
      ST_HEAD_WT: state_d = ST_CHK;
      ST_CHK:     state_d = (cur_q >= NO_ENTRY) ? ST_MISS : ST_ENT_WT;
      ST_ENT_WT:  state_d = (key_rd_q == key_l) ? ST_FOUND : ST_CHK;
      ST_FOUND: begin
        if (scan_q) state_d = ST_SCAN_NEXT;
        else if (act_q == ACT_GET) state_d = ST_IDLE;
        else if (kind_q != 4'd0) state_d = ST_COL_RD;
        else state_d = ST_UNLINK;
      end
      ST_MISS: begin
        if (scan_q) state_d = ST_SCAN_NEXT;
        else if (act_q == ACT_GET || kind_q == 4'd0 || vc_q >= NO_ENTRY) state_d = ST_IDLE;
        else state_d = ST_POOL_RD;
      end
      ST_UNLINK:    state_d = in_map ? ST_HASH : ST_IDLE;
      ST_SCAN_NEXT: state_d = (level_q == LVW'(SCAN_LEVELS - 1)) ? ST_IDLE : ST_HASH;
      ST_POOL_RD:   state_d = ST_POOL_WT;
      ST_POOL_WT:   state_d = ST_COL_RD;
      ST_COL_RD:    state_d = in_map ? ST_COL_WT : ST_IDLE;
      ST_COL_WT:    state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    act_d = act_q; x_d = x_q; y_d = y_q; z_d = z_q; kind_d = kind_q;
    clr_d = clr_q; step_d = step_q; hash_d = hash_q;
    cur_d = cur_q; prev_d = prev_q; head_d = head_q; link_d = link_q;
    fkind_d = fkind_q; vc_d = vc_q; hw_d = hw_q;
    scan_d = scan_q; level_d = level_q; top_d = top_q;
    done_d = 1'b0; rsp_d = rsp_q;

    bh_we = 1'b0; bh_addr = hash_q; bh_wd = NO_ENTRY;
    key_we = 1'b0; kind_we = 1'b0; link_we = 1'b0;
    ent_addr = cur_q[CW-1:0]; key_wd = key_l; kind_wd = kind_q; link_wd = link_q;
    pool_we = 1'b0; pool_addr = vc_q[CW-1:0]; pool_wd = cur_q[CW-1:0];
    col_we = 1'b0; col_addr = col_idx; col_wd = top_q;

    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + CNW'(1);
        if (clr_q < CNW'(MAP_CELLS)) begin
          col_we = 1'b1; col_addr = clr_q[MCW-1:0]; col_wd = 16'hFFFF;
        end
        if (clr_q < CNW'(BUCKETS)) begin
          bh_we = 1'b1; bh_addr = clr_q[BW-1:0]; bh_wd = NO_ENTRY;
        end
      end
      ST_IDLE: begin
        if (start) begin
          act_d  = req_i.action;
          x_d    = req_i.coord_x;
          y_d    = req_i.coord_y;
          z_d    = req_i.coord_z;
          kind_d = req_i.block_kind;
          step_d = 2'd0;
          hash_d = '0;
          scan_d = 1'b0;
          if (req_i.action != ACT_GET && req_i.action != ACT_SET &&
              req_i.action != ACT_HEIGHT) begin
            // unused code: no change, all zero
            done_d = 1'b1; rsp_d = '0;
          end
        end
      end
      ST_HASH: begin
        hash_d = hash_q ^ mul_p[BW-1:0];
        step_d = step_q + 2'd1;
      end
      ST_HEAD_WT: begin
        head_d = bh_rd_q; cur_d = bh_rd_q; prev_d = NO_ENTRY;
      end
      ST_ENT_WT: begin
        if (key_rd_q == key_l) begin
          link_d = link_rd_q; fkind_d = kind_rd_q;
        end else begin
          prev_d = cur_q; cur_d = link_rd_q;
        end
      end
      ST_FOUND: begin
        if (scan_q) begin
          if (fkind_q != 4'd0) top_d = 16'(level_q);
        end else if (act_q == ACT_GET) begin
          done_d = 1'b1; rsp_d = '0; rsp_d.found_kind = fkind_q; rsp_d.ok = 1'b1;
        end else if (kind_q != 4'd0) begin
          kind_we = 1'b1;  // update in place, column raised next
        end
      end
      ST_MISS: begin
        if (!scan_q && (act_q == ACT_GET || kind_q == 4'd0 || vc_q >= NO_ENTRY)) begin
          done_d = 1'b1; rsp_d = '0; rsp_d.ok = (vc_q < NO_ENTRY) || act_q == ACT_GET ||
                                              kind_q == 4'd0;
        end
      end
      ST_UNLINK: begin
        if (prev_q < NO_ENTRY) begin
          link_we = 1'b1; ent_addr = prev_q[CW-1:0]; link_wd = link_q;
        end else begin
          bh_we = 1'b1; bh_wd = link_q;
        end
        // a found entry means the count is nonzero
        vc_d = vc_q - LW'(1);
        pool_we = 1'b1; pool_addr = vc_d[CW-1:0]; pool_wd = cur_q[CW-1:0];
        if (in_map) begin
          scan_d = 1'b1; level_d = '0; top_d = 16'hFFFF; step_d = 2'd0; hash_d = '0;
        end else begin
          done_d = 1'b1; rsp_d = '0; rsp_d.ok = 1'b1;
        end
      end
      ST_SCAN_NEXT: begin
        if (level_q == LVW'(SCAN_LEVELS - 1)) begin
          col_we = 1'b1; col_wd = top_q;
          scan_d = 1'b0;
          done_d = 1'b1; rsp_d = '0; rsp_d.ok = 1'b1;
        end else begin
          level_d = level_q + LVW'(1); step_d = 2'd0; hash_d = '0;
        end
      end
      ST_POOL_WT: begin
        key_we = 1'b1; kind_we = 1'b1; link_we = 1'b1;
        ent_addr = slot; link_wd = head_q;
        bh_we = 1'b1; bh_wd = {1'b0, slot};
        vc_d = vc_q + LW'(1);
        if (pool_fresh) hw_d = vc_q + LW'(1);
      end
      ST_COL_RD: begin
        if (!in_map) begin
          done_d = 1'b1; rsp_d = '0; rsp_d.ok = 1'b1;
          if (act_q == ACT_HEIGHT) rsp_d.column_top = 16'hFFFF;
        end
      end
      ST_COL_WT: begin
        done_d = 1'b1; rsp_d = '0; rsp_d.ok = 1'b1;
        if (act_q == ACT_HEIGHT) begin
          rsp_d.column_top = col_rd_q;
        end else if ($signed(y_q) > $signed(col_rd_q)) begin
          col_we = 1'b1; col_wd = y_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      step_q  <= '0;
      vc_q    <= '0;
      hw_q    <= '0;
      scan_q  <= 1'b0;
      level_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      step_q  <= step_d;
      vc_q    <= vc_d;
      hw_q    <= hw_d;
      scan_q  <= scan_d;
      level_q <= level_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d; x_q <= x_d; y_q <= y_d; z_q <= z_d; kind_q <= kind_d;
    hash_q <= hash_d; cur_q <= cur_d; prev_q <= prev_d; head_q <= head_d;
    link_q <= link_d; fkind_q <= fkind_d; top_q <= top_d; rsp_q <= rsp_d;
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // free-list count never passes the high-water mark
  a_count_le_hw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vc_q <= hw_q) else $error("voxel count above high-water mark");

  // high-water mark stays within the pool
  a_hw_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hw_q <= NO_ENTRY) else $error("high-water mark beyond pool");

  // a result only follows a cycle of work
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy) || $past(start)) else $error("result without request");

  // during a rescan the scan level stays below SCAN_LEVELS
  a_scan_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_q |-> level_q < LVW'(SCAN_LEVELS)) else $error("scan level out of range");

endmodule
